// ----- hdl/nwa_pkg.sv -----
// Shared types and constants for the weighted particle average block.
`timescale 1ns / 1ps

package nwa_pkg;

   // default geometry
   localparam int NWA_WINDOW_LEN = 12;
   localparam int NWA_VALUE_BITS = 16;

   // fixed field widths
   localparam int FIELD_W  = 16;
   localparam int WEIGHT_W = 17;
   localparam int Q_FRAC   = 16;

   localparam logic [WEIGHT_W-1:0] Q_ONE              = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_FLOOR_RESET = 17'h08000;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_WEIGHT_FLOOR = '0;

   typedef struct packed {
      logic [FIELD_W-1:0] pm25_value;
      logic [FIELD_W-1:0] pm10_value;
      logic               reading_valid;
   } nwa_req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] avg_pm25;
      logic [FIELD_W-1:0] avg_pm10;
      logic               pm25_no_data;
      logic               pm10_no_data;
   } nwa_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WLOAD,
      ST_WDIV,
      ST_WEIGHT,
      ST_ACC_MUL,
      ST_ACC_ADD,
      ST_QLOAD,
      ST_QDIV,
      ST_DONE
   } nwa_state_type;

   // datapath commands from the sequencer to each channel
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_WDIV_LOAD,
      OP_DIV_STEP,
      OP_WEIGHT,
      OP_ACC_MUL,
      OP_ACC_ADD,
      OP_QDIV_LOAD
   } nwa_op_type;

endpackage

// ----- hdl/nwa_chan.sv -----
// One channel datapath: min/max scan, serial divider, shared multiplier, accumulators.
`timescale 1ns / 1ps

module nwa_chan import nwa_pkg::*; #(
   parameter int WINDOW_LEN = NWA_WINDOW_LEN,
   parameter int VALUE_BITS = NWA_VALUE_BITS
) (
   input  logic                  clock,
   input  nwa_op_type            op,
   input  logic [VALUE_BITS-1:0] rd_value,
   input  logic [WEIGHT_W-1:0]   weight_floor,
   output logic [FIELD_W-1:0]    avg,
   output logic                  no_data
);

   localparam int LW     = $clog2(WINDOW_LEN);
   localparam int DIV_W  = WEIGHT_W + LW;
   localparam int NUM_W  = VALUE_BITS + WEIGHT_W + LW;
   localparam int DW     = (VALUE_BITS > DIV_W) ? VALUE_BITS : DIV_W;
   localparam int QW     = (VALUE_BITS > WEIGHT_W) ? VALUE_BITS : WEIGHT_W;
   localparam int MUL_W  = WEIGHT_W + QW;
   localparam int PROD_W = VALUE_BITS + WEIGHT_W;

   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [WEIGHT_W-1:0]   mult_ff, mult_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  nz_ff, nz_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         dvs_ff, dvs_in;
   logic [QW-1:0]         dvd_ff, dvd_in;
   logic [QW-1:0]         quo_ff, quo_in;

   logic [DW:0]           trial;
   logic [DW:0]           trial_diff;
   logic                  trial_take;
   logic [QW-1:0]         mul_b;
   logic [MUL_W-1:0]      mul_p;
   logic [WEIGHT_W-1:0]   wbits;
   logic [WEIGHT_W-1:0]   floor_cl;
   logic [WEIGHT_W-1:0]   quo_cl;

   // one restoring divide step per cycle
   assign trial      = {rem_ff, dvd_ff[QW-1]};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign trial_take = trial >= {1'b0, dvs_ff};

   // shared multiplier: multiplier times value, or multiplier times weight
   assign mul_b = (op == OP_ACC_MUL) ? QW'(rd_value) : QW'(weight_ff);
   assign mul_p = MUL_W'(mult_ff) * MUL_W'(mul_b);

   // weight dividend is lo * 2^16; after the preload of lo >> 1 these bits remain
   assign wbits    = {lo_ff[0], {Q_FRAC{1'b0}}};
   assign floor_cl = (weight_floor > Q_ONE) ? Q_ONE : weight_floor;
   assign quo_cl   = (quo_ff > QW'(Q_ONE)) ? Q_ONE : quo_ff[WEIGHT_W-1:0];

   // datapath next values
   always_comb begin
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      weight_in = weight_ff;
      mult_in   = mult_ff;
      num_in    = num_ff;
      div_in    = div_ff;
      prod_in   = prod_ff;
      nz_in     = nz_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      case (op)
         OP_SCAN_INIT: begin
            hi_in = VALUE_BITS'(1);
            lo_in = '1;
         end
         OP_SCAN: begin
            if (rd_value > hi_ff) hi_in = rd_value;
            if (rd_value < lo_ff) lo_in = rd_value;
         end
         OP_WDIV_LOAD: begin
            rem_in = DW'(lo_ff >> 1);
            dvs_in = DW'(hi_ff);
            dvd_in = QW'(wbits) << (QW - WEIGHT_W);
            quo_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in = trial_take ? trial_diff[DW-1:0] : trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], trial_take};
            dvd_in = dvd_ff << 1;
         end
         OP_WEIGHT: begin
            weight_in = (quo_cl < floor_cl) ? floor_cl : quo_cl;
            mult_in   = Q_ONE;
            num_in    = '0;
            div_in    = '0;
         end
         OP_ACC_MUL: begin
            prod_in = mul_p[PROD_W-1:0];
            nz_in   = (rd_value != '0);
         end
         OP_ACC_ADD: begin
            num_in  = num_ff + NUM_W'(prod_ff);
            if (nz_ff) div_in = div_ff + DIV_W'(mult_ff);
            mult_in = mul_p[Q_FRAC+WEIGHT_W-1:Q_FRAC];
         end
         OP_QDIV_LOAD: begin
            rem_in = DW'(num_ff[NUM_W-1:VALUE_BITS]);
            dvs_in = DW'(div_ff);
            dvd_in = QW'(num_ff[VALUE_BITS-1:0]) << (QW - VALUE_BITS);
            quo_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      weight_ff <= weight_in;
      mult_ff   <= mult_in;
      num_ff    <= num_in;
      div_ff    <= div_in;
      prod_ff   <= prod_in;
      nz_ff     <= nz_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
   end

   // quotient fits the value width, so its low 16 bits are the field
   assign no_data = (div_ff == '0);
   assign avg     = no_data ? '0 : quo_ff[FIELD_W-1:0];

endmodule

// ----- hdl/nowcast_weighted_average.sv -----
// A new item is taken only in idle: req_stall holds the input through the scan, both divides and
// the accumulate pass, which uses the one-bit-per-cycle divider (17 weight steps, VALUE_BITS
// average steps) and a multiply then an add per entry on the shared multiplier; a finished result
// waits in the output register meanwhile.
// Reset (synchronous): sequencer idle, write slot 0, history reads as zero, weight_floor 0.5.
`timescale 1ns / 1ps

module nowcast_weighted_average import nwa_pkg::*; #(
   parameter int WINDOW_LEN = NWA_WINDOW_LEN,
   parameter int VALUE_BITS = NWA_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nwa_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nwa_rsp_type           rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW      = $clog2(WINDOW_LEN);
   localparam int CNT_MX0 = (WINDOW_LEN > WEIGHT_W) ? WINDOW_LEN : WEIGHT_W;
   localparam int CNT_MAX = (CNT_MX0 > VALUE_BITS) ? CNT_MX0 : VALUE_BITS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int EXT_W   = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

   nwa_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [WEIGHT_W-1:0]   weight_floor_ff, weight_floor_in;
   logic [WINDOW_LEN-1:0] vld_ff, vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   nwa_rsp_type           rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] fine_mem [WINDOW_LEN];
   logic [VALUE_BITS-1:0] coarse_mem [WINDOW_LEN];
   logic [VALUE_BITS-1:0] rd_fine_ff;
   logic [VALUE_BITS-1:0] rd_coarse_ff;
   logic                  rd_vld_ff;

   logic                  req_acc;
   logic                  out_free;
   logic                  rsp_load;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         idx_dec;
   nwa_op_type            op;
   logic                  cfg_wr;
   logic [CSR_ADDR_W-3:0] cfg_reg;
   logic [EXT_W-1:0]      fine_ext;
   logic [EXT_W-1:0]      coarse_ext;
   logic [VALUE_BITS-1:0] fine_wr;
   logic [VALUE_BITS-1:0] coarse_wr;
   logic [VALUE_BITS-1:0] fine_rd;
   logic [VALUE_BITS-1:0] coarse_rd;
   logic [FIELD_W-1:0]    fine_avg;
   logic [FIELD_W-1:0]    coarse_avg;
   logic                  fine_none;
   logic                  coarse_none;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // register port
   assign pready  = 1'b1;
   assign cfg_reg = paddr[CSR_ADDR_W-1:2];
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign prdata  = (cfg_reg == REG_WEIGHT_FLOOR) ? CSR_DATA_W'(weight_floor_ff) : '0;
   assign weight_floor_in = (cfg_wr && cfg_reg == REG_WEIGHT_FLOOR) ?
                            pwdata[WEIGHT_W-1:0] : weight_floor_ff;

   // low VALUE_BITS of each reading; a bad reading is stored as zero
   assign fine_ext   = EXT_W'(req_payload.pm25_value);
   assign coarse_ext = EXT_W'(req_payload.pm10_value);
   assign fine_wr    = req_payload.reading_valid ? fine_ext[VALUE_BITS-1:0] : '0;
   assign coarse_wr  = req_payload.reading_valid ? coarse_ext[VALUE_BITS-1:0] : '0;

   assign idx_dec = (idx_ff == '0) ? AW'(WINDOW_LEN - 1) : idx_ff - AW'(1);
   assign slot_in = !req_acc ? slot_ff :
                    (slot_ff == AW'(WINDOW_LEN - 1)) ? '0 : slot_ff + AW'(1);

   always_comb begin
      vld_in = vld_ff;
      if (req_acc) vld_in[slot_ff] = 1'b1;
   end

   // history rings, registered read
   always_ff @(posedge clock) begin
      if (req_acc) begin
         fine_mem[slot_ff]   <= fine_wr;
         coarse_mem[slot_ff] <= coarse_wr;
      end
      if (rd_en) begin
         rd_fine_ff   <= fine_mem[rd_addr];
         rd_coarse_ff <= coarse_mem[rd_addr];
         rd_vld_ff    <= vld_ff[rd_addr];
      end
   end

   // entries never written since reset read as missing
   assign fine_rd   = rd_vld_ff ? rd_fine_ff : '0;
   assign coarse_rd = rd_vld_ff ? rd_coarse_ff : '0;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_acc) state_in = ST_SCAN;
         ST_SCAN:    if (cnt_ff == CNT_W'(WINDOW_LEN)) state_in = ST_WLOAD;
         ST_WLOAD:   state_in = ST_WDIV;
         ST_WDIV:    if (cnt_ff == CNT_W'(WEIGHT_W - 1)) state_in = ST_WEIGHT;
         ST_WEIGHT:  state_in = ST_ACC_MUL;
         ST_ACC_MUL: state_in = ST_ACC_ADD;
         ST_ACC_ADD: state_in = (cnt_ff == CNT_W'(WINDOW_LEN - 1)) ? ST_QLOAD : ST_ACC_MUL;
         ST_QLOAD:   state_in = ST_QDIV;
         ST_QDIV:    if (cnt_ff == CNT_W'(VALUE_BITS - 1)) state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: datapath command, ring read, counters
   always_comb begin
      op       = OP_IDLE;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op     = OP_SCAN_INIT;
               cnt_in = '0;
               idx_in = slot_ff;
            end
         end
         ST_SCAN: begin
            // data for address cnt-1 arrives while address cnt goes out
            rd_en   = (cnt_ff < CNT_W'(WINDOW_LEN));
            rd_addr = cnt_ff[AW-1:0];
            op      = (cnt_ff != '0) ? OP_SCAN : OP_IDLE;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ST_WLOAD: begin
            op     = OP_WDIV_LOAD;
            cnt_in = '0;
         end
         ST_WDIV: begin
            op     = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_WEIGHT: begin
            op      = OP_WEIGHT;
            rd_en   = 1'b1;
            rd_addr = idx_ff;
            cnt_in  = '0;
         end
         ST_ACC_MUL: begin
            op = OP_ACC_MUL;
         end
         ST_ACC_ADD: begin
            // walk newest to oldest, prefetch the next entry
            op      = OP_ACC_ADD;
            rd_en   = 1'b1;
            rd_addr = idx_dec;
            idx_in  = idx_dec;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ST_QLOAD: begin
            op     = OP_QDIV_LOAD;
            cnt_in = '0;
         end
         ST_QDIV: begin
            op     = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.avg_pm25      = fine_avg;
         rsp_in.avg_pm10      = coarse_avg;
         rsp_in.pm25_no_data  = fine_none;
         rsp_in.pm10_no_data  = coarse_none;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         slot_ff         <= '0;
         idx_ff          <= '0;
         weight_floor_ff <= WEIGHT_FLOOR_RESET;
         vld_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         slot_ff         <= slot_in;
         idx_ff          <= idx_in;
         weight_floor_ff <= weight_floor_in;
         vld_ff          <= vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   nwa_chan #(
      .WINDOW_LEN (WINDOW_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_fine (
      .clock        (clock),
      .op           (op),
      .rd_value     (fine_rd),
      .weight_floor (weight_floor_ff),
      .avg          (fine_avg),
      .no_data      (fine_none)
   );

   nwa_chan #(
      .WINDOW_LEN (WINDOW_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_coarse (
      .clock        (clock),
      .op           (op),
      .rd_value     (coarse_rd),
      .weight_floor (weight_floor_ff),
      .avg          (coarse_avg),
      .no_data      (coarse_none)
   );

   // checks
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_SCAN)
      else $error("accepted transfer did not start the scan");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= CNT_W'(WINDOW_LEN))
      else $error("scan counter ran past the window");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("finished result not handed to the output register");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> state_ff == ST_DONE)
      else $error("done state left while output register was blocked");

endmodule

// ----- bench/nowcast_weighted_average_tb.sv -----
// Self-checking testbench for the weighted twelve-hour particle average block.
`timescale 1ns / 1ps

module nowcast_weighted_average_tb;
   import nwa_pkg::*;

   localparam int WIN          = NWA_WINDOW_LEN;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 600;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   nwa_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   nwa_rsp_type           rsp_payload;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: both history rings, write slot and the floor register
   logic [WIN-1:0][FIELD_W-1:0] fine_ring   = '0;
   logic [WIN-1:0][FIELD_W-1:0] coarse_ring = '0;
   int unsigned                 ring_slot   = 0;
   logic [WEIGHT_W-1:0]         floor_reg   = WEIGHT_FLOOR_RESET;

   nwa_req_type pending_readings[$];
   nwa_rsp_type expected_avgs[$];

   int unsigned sender_idle_pct = 0;
   int unsigned recv_idle_pct   = 0;
   logic        hold_req        = 1'b0;
   logic        hold_done       = 1'b0;
   int unsigned hold_left       = 0;
   int unsigned mismatches      = 0;
   int unsigned cycle_count     = 0;

   nowcast_weighted_average dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   // one channel: weight from min/max, then newest-to-oldest decaying sum
   function automatic void weighted_mean(input logic [WIN-1:0][FIELD_W-1:0] ring,
                                         input int unsigned newest,
                                         output logic [FIELD_W-1:0] avg,
                                         output logic no_data);
      logic [63:0] hi, lo, wf, weight, mult, num, dsum, v;
      int unsigned idx;
      int          i;
      hi   = 64'd1;
      lo   = 64'hFFFF;
      wf   = (floor_reg > Q_ONE) ? 64'(Q_ONE) : 64'(floor_reg);
      mult = 64'(Q_ONE);
      num  = '0;
      dsum = '0;
      idx  = newest;
      for (i = 0; i < WIN; i++) begin
         if (64'(ring[i]) > hi) hi = 64'(ring[i]);
         if (64'(ring[i]) < lo) lo = 64'(ring[i]);
      end
      weight = (lo << Q_FRAC) / hi;
      if (weight > 64'(Q_ONE)) weight = 64'(Q_ONE);
      if (weight < wf) weight = wf;
      for (i = 0; i < WIN; i++) begin
         v = 64'(ring[idx]);
         if (v != 0) dsum += mult;
         num += v * mult;
         idx  = (idx == 0) ? WIN - 1 : idx - 1;
         mult = (mult * weight) >> Q_FRAC;
      end
      if (dsum == 0) begin
         avg     = '0;
         no_data = 1'b1;
      end else begin
         avg     = FIELD_W'(num / dsum);
         no_data = 1'b0;
      end
   endfunction

   // store one reading pair and return both averages
   function automatic nwa_rsp_type predict_average(input nwa_req_type r);
      nwa_rsp_type      p;
      logic [FIELD_W-1:0] a25, a10;
      logic             n25, n10;
      fine_ring[ring_slot]   = r.reading_valid ? r.pm25_value : '0;
      coarse_ring[ring_slot] = r.reading_valid ? r.pm10_value : '0;
      weighted_mean(fine_ring, ring_slot, a25, n25);
      weighted_mean(coarse_ring, ring_slot, a10, n10);
      ring_slot      = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
      p.avg_pm25     = a25;
      p.avg_pm10     = a10;
      p.pm25_no_data = n25;
      p.pm10_no_data = n10;
      return p;
   endfunction

   function automatic nwa_req_type reading(input logic [FIELD_W-1:0] fine, coarse,
                                           input logic ok);
      nwa_req_type r;
      r.pm25_value    = fine;
      r.pm10_value    = coarse;
      r.reading_valid = ok;
      return r;
   endfunction

   // value jittered around a slowly moving level
   function automatic logic [FIELD_W-1:0] near_level(input int unsigned lvl);
      int unsigned d, v;
      d = $urandom_range(lvl / 8);
      v = $urandom_range(1) ? lvl + d : lvl - d;
      if (v > 65535) v = 65535;
      return FIELD_W'(v);
   endfunction

   function automatic int unsigned pick_level();
      case ($urandom_range(3))
         0:       return $urandom_range(100);
         1:       return $urandom_range(2000);
         2:       return $urandom_range(65535, 60000);
         default: return $urandom_range(65535);
      endcase
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_weight_floor(input logic [WEIGHT_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_WEIGHT_FLOOR, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      floor_reg = value;
   endtask

   // edge cases: empty rings, one-sided data, extremes, flat ring, missing hour
   task automatic queue_directed();
      int i;
      pending_readings.push_back(reading(16'hFFFF, 16'hFFFF, 1'b0));
      pending_readings.push_back(reading(16'hFFFF, 16'h0000, 1'b1));
      pending_readings.push_back(reading(16'h0000, 16'hFFFF, 1'b1));
      pending_readings.push_back(reading(16'h0000, 16'h0000, 1'b1));
      pending_readings.push_back(reading(16'hFFFF, 16'hFFFF, 1'b0));
      pending_readings.push_back(reading(16'h0001, 16'hFFFF, 1'b1));
      pending_readings.push_back(reading(16'hFFFF, 16'h0001, 1'b1));
      pending_readings.push_back(reading(16'h5555, 16'hAAAA, 1'b1));
      pending_readings.push_back(reading(16'hAAAA, 16'h5555, 1'b1));
      for (i = 0; i < WIN; i++) pending_readings.push_back(reading(16'd1000, 16'd40, 1'b1));
      pending_readings.push_back(reading(16'd1000, 16'd40, 1'b0));
      pending_readings.push_back(reading(16'hFFFF, 16'hFFFE, 1'b1));
   endtask

   // mostly steady hourly series, with spikes, low readings and missing hours
   task automatic queue_random_readings(input int count);
      int          n;
      int unsigned style, lvl25, lvl10;
      lvl25 = pick_level();
      lvl10 = pick_level();
      for (n = 0; n < count; n++) begin
         style = $urandom_range(99);
         if (style < 8) begin
            pending_readings.push_back(reading(FIELD_W'($urandom_range(65535)),
                                               FIELD_W'($urandom_range(65535)), 1'b0));
         end else if (style < 20) begin
            pending_readings.push_back(reading(FIELD_W'($urandom_range(65535)),
                                               FIELD_W'($urandom_range(65535)),
                                               1'($urandom_range(1))));
         end else if (style < 30) begin
            pending_readings.push_back(reading(FIELD_W'($urandom_range(20)),
                                               FIELD_W'($urandom_range(20)), 1'b1));
         end else begin
            if ($urandom_range(15) == 0) lvl25 = pick_level();
            if ($urandom_range(15) == 0) lvl10 = pick_level();
            pending_readings.push_back(reading(near_level(lvl25), near_level(lvl10), 1'b1));
         end
      end
   endtask

   // wait until every item is transferred and every average has come back
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_readings.size() != 0 || req_valid || expected_avgs.size() != 0);
   endtask

   // input driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_avgs.push_back(predict_average(req_payload));
         if (!req_valid || !req_stall) begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_payload <= pending_readings.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: random, or one long hold-off when requested
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      nwa_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_avgs.size() == 0) begin
            $error("unexpected result transfer: avg_pm25 %0d avg_pm10 %0d",
                   rsp_payload.avg_pm25, rsp_payload.avg_pm10);
            mismatches++;
         end else begin
            want = expected_avgs.pop_front();
            check_field("avg_pm25", 32'(want.avg_pm25), 32'(rsp_payload.avg_pm25));
            check_field("avg_pm10", 32'(want.avg_pm10), 32'(rsp_payload.avg_pm10));
            check_field("pm25_no_data", 32'(want.pm25_no_data),
                        32'(rsp_payload.pm25_no_data));
            check_field("pm10_no_data", 32'(want.pm10_no_data),
                        32'(rsp_payload.pm10_no_data));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed items at the reset floor
      @(negedge clock);
      sender_idle_pct = 21;
      recv_idle_pct   = 70;
      queue_directed();
      wait_for_drain();

      // no floor: weight follows min/max alone
      write_weight_floor('0);
      @(negedge clock);
      queue_random_readings(170);
      wait_for_drain();

      // floor of one: flat weights; long output hold-off backs up the input
      write_weight_floor(Q_ONE);
      @(negedge clock);
      sender_idle_pct = 70;
      recv_idle_pct   = 21;
      hold_req        = 1'b1;
      queue_random_readings(150);
      wait_for_drain();

      // floor above one acts as one; no idling from here on
      write_weight_floor({WEIGHT_W{1'b1}});
      @(negedge clock);
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      queue_random_readings(90);
      wait_for_drain();

      write_weight_floor(WEIGHT_W'($urandom_range(32'h1FFFF)));
      @(negedge clock);
      queue_random_readings(90);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- nowcast_weighted_average.f -----
hdl/nwa_pkg.sv
hdl/nwa_chan.sv
hdl/nowcast_weighted_average.sv
bench/nowcast_weighted_average_tb.sv
